### src/text_console_cell_buffer_assert.svh
// ----------------------------------------------------------------------------
// Text console cell buffer: assertion macros
// Concurrent assertion wrappers clocked on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CELL_BUFFER_ASSERT_SVH
`define TEXT_CONSOLE_CELL_BUFFER_ASSERT_SVH

// A condition that must hold at every clock edge out of reset.
`define TXCB_ASSERT_ALWAYS(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// An implication checked at every clock edge out of reset.
`define TXCB_ASSERT_IMPLY(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

### src/txcb_pkg.sv
// ----------------------------------------------------------------------------
// Text console cell buffer: package
// Field widths, character codes, register indexes, payload and state types.
// ----------------------------------------------------------------------------
package txcb_pkg;

  localparam int unsigned MAX_ROWS_DEF = 64;
  localparam int unsigned MAX_COLS_DEF = 128;

  localparam int unsigned ROW_W   = 7;   // num_rows register and row counters
  localparam int unsigned COL_W   = 8;   // num_cols register and column counters
  localparam int unsigned CUR_W   = 14;  // linear cursor index
  localparam int unsigned CH_W    = 8;
  localparam int unsigned RROW_W  = 6;
  localparam int unsigned RCOL_W  = 7;
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam int unsigned REG_IDX_BIT = 2;

  localparam int unsigned RESET_ROWS = 24;
  localparam int unsigned RESET_COLS = 80;

  localparam logic [CH_W-1:0] CH_BS    = 8'd8;
  localparam logic [CH_W-1:0] CH_NL    = 8'd10;
  localparam logic [CH_W-1:0] CH_FF    = 8'd12;
  localparam logic [CH_W-1:0] CH_CR    = 8'd13;
  localparam logic [CH_W-1:0] CH_SPACE = 8'h20;

  localparam logic REQ_PUT  = 1'b0;
  localparam logic REQ_READ = 1'b1;

  localparam logic REG_NUM_ROWS = 1'b0;
  localparam logic REG_NUM_COLS = 1'b1;

  typedef struct packed {
    logic              req_type;
    logic [CH_W-1:0]   char_code;
    logic [RROW_W-1:0] read_row;
    logic [RCOL_W-1:0] read_col;
  } in_t;

  typedef struct packed {
    logic [CH_W-1:0]  read_char;
    logic [CUR_W-1:0] cursor_position;
  } out_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCROLL,
    ST_EXEC,
    ST_READ
  } st_e;

endpackage

### src/text_console_cell_buffer.sv
// ----------------------------------------------------------------------------
// Text console cell buffer
// Character-cell console: puts characters with cursor control and scrolling,
// and reads back cells by screen row and column.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake              | Payload
//  --------+------------------------+------------------------------------
//  in      | in_valid_i/in_ready_o  | in_data_i  (req_type, char_code, row, col)
//  out     | out_valid_o/out_ready_i| out_data_o (read_char, cursor_position)
//  config  | psel/penable/pready    | paddr, pwdata, prdata (num_rows, num_cols)
//
// A put passes the states IDLE and EXEC, a read IDLE, EXEC and READ; the
// memory's single registered read port adds the READ state. A put that finds
// the cursor past the last cell first blanks the new bottom row, one cell a
// cycle. Reset, a form feed and any register write clear the screen, one cell
// a cycle over all num_rows*num_cols cells (1920 after reset); no transaction
// is accepted meanwhile. A full output register holds the next result back.
// ----------------------------------------------------------------------------
`include "text_console_cell_buffer_assert.svh"

module text_console_cell_buffer #(
  parameter int unsigned MAX_ROWS = txcb_pkg::MAX_ROWS_DEF,
  parameter int unsigned MAX_COLS = txcb_pkg::MAX_COLS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [txcb_pkg::PADDR_W-1:0]  paddr,
  input  logic [txcb_pkg::PDATA_W-1:0]  pwdata,
  output logic [txcb_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  txcb_pkg::in_t                 in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output txcb_pkg::out_t                out_data_o
);
  import txcb_pkg::*;

  localparam int unsigned DEPTH = MAX_ROWS * MAX_COLS;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [ROW_W-1:0] RST_ROWS =
    ROW_W'((RESET_ROWS > MAX_ROWS) ? MAX_ROWS : RESET_ROWS);
  localparam logic [COL_W-1:0] RST_COLS =
    COL_W'((RESET_COLS > MAX_COLS) ? MAX_COLS : RESET_COLS);

  st_e               state_q, state_d;
  logic [ROW_W-1:0]  num_rows_q, num_rows_d;
  logic [COL_W-1:0]  num_cols_q, num_cols_d;
  logic [ROW_W-1:0]  top_q, top_d;
  logic [ROW_W-1:0]  cur_row_q, cur_row_d;
  logic [COL_W-1:0]  cur_col_q, cur_col_d;
  logic [CUR_W-1:0]  cur_lin_q, cur_lin_d;
  logic [ROW_W-1:0]  sw_row_q, sw_row_d;
  logic [COL_W-1:0]  sw_col_q, sw_col_d;
  in_t               req_q, req_d;
  logic              out_valid_q, out_valid_d;
  out_t              out_q, out_d;
  logic [CH_W-1:0]   rdata_q;
  logic [CH_W-1:0]   char_mem_q [DEPTH];

  logic              cfg_wr;
  logic              out_free;
  logic              out_load;
  logic              need_scroll;
  logic              sweep_row_end;
  logic              sweep_col_end;
  logic              rd_ok;
  logic [ROW_W-1:0]  cur_phys;
  logic [ROW_W-1:0]  rd_phys;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [CH_W-1:0]   mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;

  // Screen row to physical row in the ring; for rows on the screen the sum stays below twice num_rows.
  function automatic logic [ROW_W-1:0] ring_row(logic [ROW_W:0] sum, logic [ROW_W-1:0] rows);
    logic [ROW_W:0] rows_x;
    rows_x = {1'b0, rows};
    if (sum >= rows_x) begin
      return ROW_W'(sum - rows_x);
    end
    return sum[ROW_W-1:0];
  endfunction

  function automatic logic [AW-1:0] cell_addr(logic [ROW_W-1:0] prow, logic [COL_W-1:0] col);
    return AW'(32'(prow) * MAX_COLS + 32'(col));
  endfunction

  function automatic logic [ROW_W-1:0] clamp_rows(logic [ROW_W-1:0] v);
    if (v == '0) begin
      return ROW_W'(1);
    end
    if (32'(v) > MAX_ROWS) begin
      return ROW_W'(MAX_ROWS);
    end
    return v;
  endfunction

  function automatic logic [COL_W-1:0] clamp_cols(logic [COL_W-1:0] v);
    if (v == '0) begin
      return COL_W'(1);
    end
    if (32'(v) > MAX_COLS) begin
      return COL_W'(MAX_COLS);
    end
    return v;
  endfunction

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[REG_IDX_BIT] == REG_NUM_COLS) ? PDATA_W'(num_cols_q)
                                                       : PDATA_W'(num_rows_q);

  // --------------------------------------------------------------------------
  // Shared decode
  // --------------------------------------------------------------------------
  assign in_ready_o    = (state_q == ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign out_data_o    = out_q;
  assign out_free      = !out_valid_q || out_ready_i;
  assign need_scroll   = (in_data_i.req_type == REQ_PUT) && (in_data_i.char_code != CH_FF) &&
                         (cur_row_q == num_rows_q);
  assign sweep_col_end = (sw_col_q == num_cols_q - COL_W'(1));
  assign sweep_row_end = (sw_row_q == num_rows_q - ROW_W'(1));
  assign cur_phys      = ring_row({1'b0, top_q} + {1'b0, cur_row_q}, num_rows_q);
  assign rd_phys       = ring_row({1'b0, top_q} + (ROW_W+1)'(req_q.read_row), num_rows_q);
  assign rd_ok         = (ROW_W'(req_q.read_row) < num_rows_q) &&
                         (COL_W'(req_q.read_col) < num_cols_q);
  assign mem_raddr     = cell_addr(rd_phys, COL_W'(req_q.read_col));

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (sweep_row_end && sweep_col_end) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = need_scroll ? ST_SCROLL : ST_EXEC;
        end
      end
      ST_SCROLL: begin
        if (sweep_col_end) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (req_q.req_type == REQ_READ) begin
          state_d = ST_READ;
        end else if (out_free) begin
          state_d = (req_q.char_code == CH_FF) ? ST_CLEAR : ST_IDLE;
        end
      end
      ST_READ: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
    if (cfg_wr) begin
      state_d = ST_CLEAR;
    end
  end

  // --------------------------------------------------------------------------
  // Datapath and memory control
  // --------------------------------------------------------------------------
  always_comb begin
    num_rows_d = num_rows_q;
    num_cols_d = num_cols_q;
    top_d      = top_q;
    cur_row_d  = cur_row_q;
    cur_col_d  = cur_col_q;
    cur_lin_d  = cur_lin_q;
    sw_row_d   = sw_row_q;
    sw_col_d   = sw_col_q;
    req_d      = req_q;
    out_load   = 1'b0;
    out_d      = out_q;
    mem_we     = 1'b0;
    mem_waddr  = cell_addr(sw_row_q, sw_col_q);
    mem_wdata  = CH_SPACE;
    mem_re     = 1'b0;

    case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
        if (sweep_col_end) begin
          sw_col_d = '0;
          sw_row_d = sw_row_q + ROW_W'(1);
        end else begin
          sw_col_d = sw_col_q + COL_W'(1);
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          req_d = in_data_i;
          if (need_scroll) begin
            // The old top row becomes the new bottom row and is blanked.
            top_d     = (top_q == num_rows_q - ROW_W'(1)) ? '0 : top_q + ROW_W'(1);
            sw_row_d  = top_q;
            sw_col_d  = '0;
            cur_row_d = num_rows_q - ROW_W'(1);
            cur_col_d = '0;
            cur_lin_d = cur_lin_q - CUR_W'(num_cols_q);
          end
        end
      end
      ST_SCROLL: begin
        mem_we   = 1'b1;
        sw_col_d = sw_col_q + COL_W'(1);
      end
      ST_EXEC: begin
        if (req_q.req_type == REQ_READ) begin
          mem_re = 1'b1;
        end else if (out_free) begin
          case (req_q.char_code)
            CH_FF: begin
              top_d     = '0;
              cur_row_d = '0;
              cur_col_d = '0;
              cur_lin_d = '0;
              sw_row_d  = '0;
              sw_col_d  = '0;
            end
            CH_NL: begin
              cur_row_d = cur_row_q + ROW_W'(1);
              cur_col_d = '0;
              cur_lin_d = cur_lin_q - CUR_W'(cur_col_q) + CUR_W'(num_cols_q);
            end
            CH_CR: begin
              cur_col_d = '0;
              cur_lin_d = cur_lin_q - CUR_W'(cur_col_q);
            end
            CH_BS: begin
              if (cur_col_q != '0) begin
                cur_col_d = cur_col_q - COL_W'(1);
                cur_lin_d = cur_lin_q - CUR_W'(1);
                mem_we    = 1'b1;
                mem_waddr = cell_addr(cur_phys, cur_col_q - COL_W'(1));
              end
            end
            default: begin
              mem_we    = 1'b1;
              mem_waddr = cell_addr(cur_phys, cur_col_q);
              mem_wdata = req_q.char_code;
              cur_lin_d = cur_lin_q + CUR_W'(1);
              if (cur_col_q == num_cols_q - COL_W'(1)) begin
                cur_col_d = '0;
                cur_row_d = cur_row_q + ROW_W'(1);
              end else begin
                cur_col_d = cur_col_q + COL_W'(1);
              end
            end
          endcase
          out_load = 1'b1;
          out_d.read_char       = '0;
          out_d.cursor_position = cur_lin_d;
        end
      end
      ST_READ: begin
        if (out_free) begin
          out_load = 1'b1;
          out_d.read_char       = rd_ok ? rdata_q : '0;
          out_d.cursor_position = cur_lin_q;
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase

    // A register write restarts the screen from a full clear.
    if (cfg_wr) begin
      if (paddr[REG_IDX_BIT] == REG_NUM_COLS) begin
        num_cols_d = clamp_cols(pwdata[COL_W-1:0]);
      end else begin
        num_rows_d = clamp_rows(pwdata[ROW_W-1:0]);
      end
      top_d     = '0;
      cur_row_d = '0;
      cur_col_d = '0;
      cur_lin_d = '0;
      sw_row_d  = '0;
      sw_col_d  = '0;
    end
  end

  assign out_valid_d = out_load || (out_valid_q && !out_ready_i);

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      num_rows_q  <= RST_ROWS;
      num_cols_q  <= RST_COLS;
      top_q       <= '0;
      cur_row_q   <= '0;
      cur_col_q   <= '0;
      cur_lin_q   <= '0;
      sw_row_q    <= '0;
      sw_col_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      num_rows_q  <= num_rows_d;
      num_cols_q  <= num_cols_d;
      top_q       <= top_d;
      cur_row_q   <= cur_row_d;
      cur_col_q   <= cur_col_d;
      cur_lin_q   <= cur_lin_d;
      sw_row_q    <= sw_row_d;
      sw_col_q    <= sw_col_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    if (out_load) begin
      out_q <= out_d;
    end
  end

  // Only one transaction is in flight, so a read never overlaps a write to
  // the same cell; the read data register holds until the next read.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      char_mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= char_mem_q[mem_raddr];
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `TXCB_ASSERT_ALWAYS(a_col_range, cur_col_q < num_cols_q, "cursor column beyond num_cols")
  `TXCB_ASSERT_ALWAYS(a_row_range, (cur_row_q < num_rows_q) || ((cur_row_q == num_rows_q) && (cur_col_q == '0)), "cursor row beyond screen")
  `TXCB_ASSERT_ALWAYS(a_top_range, top_q < num_rows_q, "top row pointer beyond num_rows")
  `TXCB_ASSERT_IMPLY(a_out_slot, out_load, !out_valid_q || out_ready_i, "result overwrites pending result")

endmodule

### tb/tb_text_console_cell_buffer.sv
// ----------------------------------------------------------------------------
// Text console cell buffer testbench
// Drives put and read requests through the valid/ready input channel and
// programs the screen size over the APB port. A behavioral model of the
// console screen, cursor and row ring predicts every reply, and a monitor
// compares each accepted reply with the oldest prediction. Both channels
// idle at random, and one long receiver hold-off fills the block.
// ----------------------------------------------------------------------------
module tb_text_console_cell_buffer;
  timeunit 1ns;
  timeprecision 1ps;

  import txcb_pkg::*;

  localparam int unsigned CLK_PERIOD  = 20;
  localparam int unsigned QUIET_LIMIT = 40000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned SHOWN_ERRORS = 10;
  localparam int unsigned SCR_AW = $clog2(MAX_ROWS_DEF * MAX_COLS_DEF);

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;
  logic                in_valid_i;
  logic                in_ready_o;
  in_t                 in_data_i;
  logic                out_valid_o;
  logic                out_ready_i;
  out_t                out_data_o;

  // Model of the console: physical cell grid, cursor, top row and geometry.
  logic [CH_W-1:0] screen [MAX_ROWS_DEF*MAX_COLS_DEF];
  int unsigned     cur_idx;
  int unsigned     top_phys;
  int unsigned     rows_used;
  int unsigned     cols_used;

  out_t        char_cursor_fifo [$];
  out_t        want;
  int unsigned mismatches  = 0;
  int unsigned replies     = 0;
  int unsigned quiet_cycles = 0;
  int unsigned burst_left  = 0;
  bit          hold_request = 1'b0;

  always #(CLK_PERIOD/2) clk_i = ~clk_i;

  text_console_cell_buffer u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // --------------------------------------------------------------------------
  // Console model
  // --------------------------------------------------------------------------
  function automatic void blank_screen();
    foreach (screen[i]) screen[i] = CH_SPACE;
    cur_idx  = 0;
    top_phys = 0;
  endfunction

  function automatic int unsigned dim_limit(int unsigned v, int unsigned vmax);
    if (v == 0) return 1;
    if (v > vmax) return vmax;
    return v;
  endfunction

  function automatic logic [SCR_AW-1:0] phys_addr(int unsigned row, int unsigned col);
    return SCR_AW'(((top_phys + row) % rows_used) * MAX_COLS_DEF + col);
  endfunction

  function automatic void set_geometry(logic idx, logic [PDATA_W-1:0] value);
    if (idx == REG_NUM_ROWS) begin
      rows_used = dim_limit(32'(value[ROW_W-1:0]), MAX_ROWS_DEF);
    end else begin
      cols_used = dim_limit(32'(value[COL_W-1:0]), MAX_COLS_DEF);
    end
    blank_screen();
  endfunction

  function automatic out_t console_step(in_t req);
    out_t        rep;
    int unsigned col;
    int unsigned bottom;
    int unsigned c;
    rep = '0;
    if (req.req_type == REQ_PUT) begin
      // A cursor past the last cell scrolls the ring before anything else.
      if (cur_idx >= rows_used * cols_used) begin
        top_phys = (top_phys + 1) % rows_used;
        bottom   = (top_phys + rows_used - 1) % rows_used;
        for (c = 0; c < MAX_COLS_DEF; c++) begin
          screen[SCR_AW'(bottom*MAX_COLS_DEF + c)] = CH_SPACE;
        end
        cur_idx = cols_used * (rows_used - 1);
      end
      col = cur_idx % cols_used;
      case (req.char_code)
        CH_FF: blank_screen();
        CH_NL: cur_idx = (cur_idx / cols_used + 1) * cols_used;
        CH_CR: cur_idx = cur_idx - col;
        CH_BS: begin
          if (col != 0) begin
            cur_idx = cur_idx - 1;
            screen[phys_addr(cur_idx / cols_used, col - 1)] = CH_SPACE;
          end
        end
        default: begin
          screen[phys_addr(cur_idx / cols_used, col)] = req.char_code;
          cur_idx = cur_idx + 1;
        end
      endcase
    end else if (32'(req.read_row) < rows_used && 32'(req.read_col) < cols_used) begin
      rep.read_char = screen[phys_addr(32'(req.read_row), 32'(req.read_col))];
    end
    rep.cursor_position = CUR_W'(cur_idx);
    return rep;
  endfunction

  // --------------------------------------------------------------------------
  // Request builders
  // --------------------------------------------------------------------------
  function automatic in_t put_req(logic [CH_W-1:0] ch);
    in_t r;
    r.req_type  = REQ_PUT;
    r.char_code = ch;
    r.read_row  = RROW_W'($urandom());
    r.read_col  = RCOL_W'($urandom());
    return r;
  endfunction

  function automatic in_t read_req(int unsigned row, int unsigned col);
    in_t r;
    r.req_type  = REQ_READ;
    r.char_code = CH_W'($urandom());
    r.read_row  = RROW_W'(row);
    r.read_col  = RCOL_W'(col);
    return r;
  endfunction

  function automatic in_t random_req(int unsigned ff_odds);
    in_t         r;
    int unsigned pick;
    r = put_req(CH_W'($urandom_range(0, 255)));
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      r.req_type = REQ_READ;
      // Most reads land on the visible screen; the rest use any address.
      if (pick < 20) begin
        r.read_row = RROW_W'($urandom_range(0, rows_used - 1));
        r.read_col = RCOL_W'($urandom_range(0, cols_used - 1));
      end
    end else if (pick < 33) begin
      r.char_code = CH_NL;
    end else if (pick < 38) begin
      r.char_code = CH_CR;
    end else if (pick < 46) begin
      r.char_code = CH_BS;
    end else if ($urandom_range(1, ff_odds) == 1) begin
      r.char_code = CH_FF;
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Drivers (entered and left at a falling edge)
  // --------------------------------------------------------------------------
  task automatic send_req(input in_t req);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 12);
      repeat (gap) @(negedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 16);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    char_cursor_fifo.push_back(console_step(req));
    burst_left--;
    @(negedge clk_i);
    if (burst_left == 0) in_valid_i <= 1'b0;
  endtask

  task automatic hold_input();
    if (burst_left != 0) in_valid_i <= 1'b0;
    burst_left = 0;
  endtask

  task automatic wait_drained();
    while (char_cursor_fifo.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [PDATA_W-1:0] value);
    hold_input();
    wait_drained();
    // A form feed may still be clearing the screen after its reply.
    while (!in_ready_o) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(idx) << REG_IDX_BIT;
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    set_geometry(idx, value);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_screen(input int unsigned rows_raw, input int unsigned cols_raw);
    logic [PDATA_W-1:0] rv;
    logic [PDATA_W-1:0] cv;
    rv = $urandom();
    cv = $urandom();
    rv[ROW_W-1:0] = ROW_W'(rows_raw);
    cv[COL_W-1:0] = COL_W'(cols_raw);
    if ($urandom_range(0, 1) == 0) begin
      write_reg(REG_NUM_ROWS, rv);
      write_reg(REG_NUM_COLS, cv);
    end else begin
      write_reg(REG_NUM_COLS, cv);
      write_reg(REG_NUM_ROWS, rv);
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_reset_screen();
    send_req(read_req(0, 0));
    send_req(put_req(8'h00));
    send_req(put_req(8'hFF));
    send_req(put_req(CH_BS));
    send_req(read_req(0, 1));
    send_req(put_req(CH_CR));
    send_req(put_req(CH_BS));
    send_req(put_req(CH_NL));
    send_req(read_req(RESET_ROWS - 1, RESET_COLS - 1));
    send_req(read_req(63, 127));
    send_req(read_req(0, RESET_COLS));
    send_req(put_req(CH_FF));
    hold_input();
  endtask

  task automatic test_scroll();
    set_screen(2, 3);
    send_req(put_req(8'h61));
    send_req(put_req(CH_NL));
    send_req(put_req(8'h62));
    send_req(put_req(8'h63));
    send_req(put_req(8'h64));
    // The cursor sits past the last cell, so this newline scrolls first.
    send_req(put_req(CH_NL));
    send_req(put_req(CH_BS));
    send_req(put_req(8'h65));
    send_req(read_req(1, 0));
    hold_input();
  endtask

  task automatic test_register_extremes();
    set_screen(0, 0);
    send_req(put_req(8'h78));
    send_req(put_req(8'h79));
    send_req(read_req(0, 0));
    set_screen(127, 255);
    send_req(put_req(8'h7A));
    send_req(read_req(63, 127));
    hold_input();
  endtask

  task automatic run_phase(input int unsigned rows_raw, input int unsigned cols_raw,
                           input int unsigned n_items);
    int unsigned ff_odds;
    set_screen(rows_raw, cols_raw);
    // Clearing a large screen is slow, so form feeds are rare there.
    ff_odds = (rows_used * cols_used > 1024) ? 200 : 30;
    repeat (n_items) send_req(random_req(ff_odds));
    hold_input();
  endtask

  task automatic test_random_screens();
    run_phase(1, 1, 100);
    run_phase(2, 5, 150);
    run_phase(4, 8, 200);
    run_phase(3, 128, 120);
    run_phase(64, 1, 120);
    run_phase($urandom_range(5, 12), $urandom_range(9, 40), 200);
    run_phase(100, 180, 100);
    run_phase(RESET_ROWS, RESET_COLS, 100);
  endtask

  task automatic test_backpressure();
    // The receiver stops taking replies while every transaction is offered
    // back to back, so the block has to stall its input.
    hold_request = 1'b1;
    burst_left   = 80;
    repeat (60) send_req(random_req(200));
    hold_input();
  endtask

  // --------------------------------------------------------------------------
  // Receiver: ready patterns that change now and then, plus the long hold.
  // --------------------------------------------------------------------------
  initial begin : receiver
    int unsigned mode;
    int unsigned left;
    left = 0;
    mode = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_request = 1'b0;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(20, 300);
        end
        left--;
        case (mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= 1'($urandom_range(0, 1));
          2: out_ready_i <= ($urandom_range(0, 3) == 0);
          default: out_ready_i <= (left % 5 != 0);
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Reply checker and watchdog
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      replies++;
      if (char_cursor_fifo.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOWN_ERRORS) begin
          $display("ERROR: reply %0d has no request: char %h cursor %0d",
                   replies, out_data_o.read_char, out_data_o.cursor_position);
        end
      end else begin
        want = char_cursor_fifo.pop_front();
        if (out_data_o.read_char !== want.read_char ||
            out_data_o.cursor_position !== want.cursor_position) begin
          mismatches++;
          if (mismatches <= SHOWN_ERRORS) begin
            $display("ERROR: reply %0d: expected char %h cursor %0d, got char %h cursor %0d",
                     replies, want.read_char, want.cursor_position,
                     out_data_o.read_char, out_data_o.cursor_position);
          end
        end
      end
    end
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (psel && penable)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("ERROR: no transaction for %0d cycles", QUIET_LIMIT);
        $display("text_console_cell_buffer: mismatch");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni     = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    rows_used  = RESET_ROWS;
    cols_used  = RESET_COLS;
    blank_screen();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_screen();
    test_scroll();
    test_register_extremes();
    test_random_screens();
    test_backpressure();

    wait_drained();
    repeat (200) @(posedge clk_i);
    if (mismatches == 0 && char_cursor_fifo.size() == 0) begin
      $display("text_console_cell_buffer: match");
    end else begin
      $display("text_console_cell_buffer: mismatch");
    end
    $finish;
  end

endmodule
